// ===== rtl/imu_afp_pkg.sv =====
`timescale 1ns / 1ps
// Package for the IMU angle frame parser: frame constants, widths and shared types.
// No dependencies; imported by every module in rtl/.
package imu_afp_pkg;

    localparam int WIN_LEN    = 11;
    localparam int FILL_W     = 4;
    localparam int ANGLE_W    = 17;
    localparam int CFG_IDX_W  = 8;

    localparam logic [7:0] HDR_BYTE   = 8'h55;
    localparam logic [7:0] TYPE_ANGLE = 8'h53;

    localparam logic [CFG_IDX_W-1:0] CFG_ROLL_INVERT  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PITCH_INVERT = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_YAW_INVERT   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_YAW_OFFSET   = 8'd3;

    typedef struct packed {
        logic                       roll_invert;
        logic                       pitch_invert;
        logic                       yaw_invert;
        logic signed [ANGLE_W-1:0]  yaw_zero_offset;
    } cfg_t;

    typedef struct packed {
        logic               fire;
        logic signed [15:0] roll_raw;
        logic signed [15:0] pitch_raw;
        logic signed [15:0] yaw_raw;
    } frame_t;

endpackage

// ===== rtl/imu_afp_window.sv =====
`timescale 1ns / 1ps
// Byte window and fill count, frame header/checksum check and resync shift.
// Depends on imu_afp_pkg.
module imu_afp_window
    import imu_afp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] rx_byte,
    output frame_t     frame
);

    logic [7:0]        window_reg [WIN_LEN];
    logic [7:0]        window_next [WIN_LEN];
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic [FILL_W-1:0] wr_idx;
    logic              last_byte;
    logic [7:0]        s01, s23, s45, s67, s89, s03, s47, s07, sum;
    logic              frame_ok;

    assign wr_idx    = (fill_reg >= FILL_W'(WIN_LEN)) ? '0 : fill_reg;
    assign last_byte = (wr_idx == FILL_W'(WIN_LEN - 1));

    assign s01 = window_reg[0] + window_reg[1];
    assign s23 = window_reg[2] + window_reg[3];
    assign s45 = window_reg[4] + window_reg[5];
    assign s67 = window_reg[6] + window_reg[7];
    assign s89 = window_reg[8] + window_reg[9];
    assign s03 = s01 + s23;
    assign s47 = s45 + s67;
    assign s07 = s03 + s47;
    assign sum = s07 + s89;

    assign frame_ok = last_byte && (window_reg[0] == HDR_BYTE) && (sum == rx_byte);

    assign frame.fire      = accept && frame_ok && (window_reg[1] == TYPE_ANGLE);
    assign frame.roll_raw  = {window_reg[3], window_reg[2]};
    assign frame.pitch_raw = {window_reg[5], window_reg[4]};
    assign frame.yaw_raw   = {window_reg[7], window_reg[6]};

    always_comb
    begin
        for (int i = 0; i < WIN_LEN; i++)
        begin
            window_next[i] = window_reg[i];
        end
        fill_next = fill_reg;
        if (!last_byte)
        begin
            for (int i = 0; i < WIN_LEN; i++)
            begin
                if (wr_idx == FILL_W'(i))
                begin
                    window_next[i] = rx_byte;
                end
            end
            fill_next = wr_idx + FILL_W'(1);
        end
        else if (frame_ok)
        begin
            fill_next = '0;
        end
        else
        begin
            // drop oldest byte to resync
            for (int i = 0; i < WIN_LEN - 2; i++)
            begin
                window_next[i] = window_reg[i+1];
            end
            window_next[WIN_LEN-2] = rx_byte;
            fill_next = FILL_W'(WIN_LEN - 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            for (int i = 0; i < WIN_LEN; i++)
            begin
                window_reg[i] <= '0;
            end
        end
        else if (accept)
        begin
            fill_reg <= fill_next;
            for (int i = 0; i < WIN_LEN; i++)
            begin
                window_reg[i] <= window_next[i];
            end
        end
    end

endmodule

// ===== rtl/imu_afp_angle.sv =====
`timescale 1ns / 1ps
// Angle conversion (sign, yaw wrap, offset) and the output result register.
// Depends on imu_afp_pkg.
module imu_afp_angle
    import imu_afp_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  frame_t                    frame,
    input  cfg_t                      cfg,
    input  logic                      out_stall,
    output logic                      out_valid,
    output logic signed [ANGLE_W-1:0] roll_angle,
    output logic signed [ANGLE_W-1:0] pitch_angle,
    output logic signed [ANGLE_W-1:0] yaw_angle
);

    localparam int DIFF_W = ANGLE_W + 2;
    localparam logic signed [DIFF_W-1:0] HALF_TURN = DIFF_W'(32768);
    localparam logic signed [DIFF_W-1:0] FULL_TURN = DIFF_W'(65536);

    logic                      out_valid_reg;
    logic signed [ANGLE_W-1:0] roll_reg, pitch_reg, yaw_reg;
    logic signed [ANGLE_W-1:0] roll_ext, pitch_ext, yaw_ext;
    logic signed [ANGLE_W-1:0] roll_next, pitch_next, yaw_sgn;
    logic signed [DIFF_W-1:0]  yaw_w1, yaw_diff, yaw_w2;

    assign roll_ext  = ANGLE_W'(frame.roll_raw);
    assign pitch_ext = ANGLE_W'(frame.pitch_raw);
    assign yaw_ext   = ANGLE_W'(frame.yaw_raw);

    assign roll_next  = cfg.roll_invert  ? -roll_ext  : roll_ext;
    assign pitch_next = cfg.pitch_invert ? -pitch_ext : pitch_ext;
    assign yaw_sgn    = cfg.yaw_invert   ? -yaw_ext   : yaw_ext;

    always_comb
    begin
        yaw_w1 = DIFF_W'(yaw_sgn);
        if (yaw_w1 > HALF_TURN)
        begin
            yaw_w1 = yaw_w1 - FULL_TURN;
        end
        else if (yaw_w1 <= -HALF_TURN)
        begin
            yaw_w1 = yaw_w1 + FULL_TURN;
        end
        yaw_diff = yaw_w1 - DIFF_W'(cfg.yaw_zero_offset);
        yaw_w2   = yaw_diff;
        if (yaw_diff > HALF_TURN)
        begin
            yaw_w2 = yaw_diff - FULL_TURN;
        end
        else if (yaw_diff <= -HALF_TURN)
        begin
            yaw_w2 = yaw_diff + FULL_TURN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (frame.fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame.fire)
        begin
            roll_reg  <= roll_next;
            pitch_reg <= pitch_next;
            yaw_reg   <= yaw_w2[ANGLE_W-1:0];
        end
    end

    assign out_valid   = out_valid_reg;
    assign roll_angle  = roll_reg;
    assign pitch_angle = pitch_reg;
    assign yaw_angle   = yaw_reg;

endmodule

// ===== rtl/imu_angle_frame_parser.sv =====
`timescale 1ns / 1ps
// IMU angle frame parser top level: configuration registers, window, angle output.
// Depends on imu_afp_pkg, imu_afp_window and imu_afp_angle.
//
// Input channel: in_valid / in_stall with one serial byte (rx_byte) per transaction.
// Output channel: out_valid / out_stall with roll_angle, pitch_angle, yaw_angle.
// Configuration channel: cfg_valid / cfg_ready with cfg_index and cfg_data;
// cfg_ready is always high, unknown indexes are ignored.
// A byte is taken in every cycle with in_valid high and in_stall low; the
// eleven-byte window, header check and 8-bit checksum are evaluated on the
// byte that completes the window. A good angle frame shows its result in the
// cycle after its last byte is accepted; the result register holds it until taken.
// in_stall rises only while a result waits and out_stall is high, so a
// stalled receiver holds off new bytes and nothing is lost.
// Reset clears the window, fill count, invert bits, yaw offset and out_valid.
module imu_angle_frame_parser
    import imu_afp_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [7:0]                rx_byte,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [ANGLE_W-1:0] roll_angle,
    output logic signed [ANGLE_W-1:0] pitch_angle,
    output logic signed [ANGLE_W-1:0] yaw_angle,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [ANGLE_W-1:0]        cfg_data
);

    cfg_t   cfg_reg;
    frame_t frame;
    logic   accept;

    assign cfg_ready = 1'b1;
    assign in_stall  = out_valid && out_stall;
    assign accept    = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_ROLL_INVERT:  cfg_reg.roll_invert     <= cfg_data[0];
                CFG_PITCH_INVERT: cfg_reg.pitch_invert    <= cfg_data[0];
                CFG_YAW_INVERT:   cfg_reg.yaw_invert      <= cfg_data[0];
                CFG_YAW_OFFSET:   cfg_reg.yaw_zero_offset <= cfg_data;
                default:          cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    imu_afp_window u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .rx_byte (rx_byte),
        .frame   (frame)
    );

    imu_afp_angle u_angle (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame       (frame),
        .cfg         (cfg_reg),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .roll_angle  (roll_angle),
        .pitch_angle (pitch_angle),
        .yaw_angle   (yaw_angle)
    );

endmodule

// ===== tb/tb_imu_angle_frame_parser.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for imu_angle_frame_parser: byte stream in, angle triples out.
// Depends on imu_afp_pkg and the RTL; a built-in window/checksum predictor checks each result.
module tb_imu_angle_frame_parser;
    import imu_afp_pkg::*;

    localparam int HALF_TURN   = 32768;
    localparam int FULL_TURN   = 65536;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 6;
    localparam int PHASE_BYTES = 330;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE      = 4;
    localparam logic [7:0] TYPE_ACCEL = 8'h51;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] roll;
        logic signed [ANGLE_W-1:0] pitch;
        logic signed [ANGLE_W-1:0] yaw;
    } angles_t;

    typedef enum logic [1:0] {FR_ANGLE, FR_OTHER, FR_BAD_HDR, FR_BAD_SUM} frame_kind_t;
    typedef enum logic [1:0] {RX_READY, RX_RANDOM, RX_PATTERN} rx_mode_t;

    typedef struct {
        frame_kind_t kind;
        logic [15:0] roll;
        logic [15:0] pitch;
        logic [15:0] yaw;
        bit          literal;
        int          want_roll;
        int          want_pitch;
        int          want_yaw;
    } frame_row_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic [7:0]                rx_byte = 8'h00;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic signed [ANGLE_W-1:0] roll_angle;
    logic signed [ANGLE_W-1:0] pitch_angle;
    logic signed [ANGLE_W-1:0] yaw_angle;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_IDX_W-1:0]      cfg_index = '0;
    logic [ANGLE_W-1:0]        cfg_data = '0;

    logic [7:0]                win_bytes[WIN_LEN];
    int                        win_fill = 0;
    logic                      inv_roll = 1'b0;
    logic                      inv_pitch = 1'b0;
    logic                      inv_yaw = 1'b0;
    logic signed [ANGLE_W-1:0] yaw_offset = '0;

    angles_t    angle_expect_q[$];
    logic [7:0] tx_bytes_q[$];
    angles_t    literal_want;
    bit         literal_armed = 1'b0;
    int         error_count = 0;
    int         cycle_count = 0;
    int         burst_left = 0;
    bit         gaps_on = 1'b1;
    rx_mode_t   rx_mode = RX_READY;
    int         hold_requests = 0;
    int         holds_served = 0;
    int         hold_left = 0;

    frame_row_t directed_rows[9] = '{
        '{FR_ANGLE,   16'h0000, 16'h0000, 16'h0000, 1'b1, 0, 0, 0},
        '{FR_ANGLE,   16'h7FFF, 16'h8000, 16'h8000, 1'b1, 32767, -32768, 32768},
        '{FR_ANGLE,   16'h8000, 16'h7FFF, 16'h7FFF, 1'b1, -32768, 32767, 32767},
        '{FR_ANGLE,   16'hFFFF, 16'h0001, 16'hFFFF, 1'b1, -1, 1, -1},
        '{FR_OTHER,   16'h1234, 16'h5678, 16'h9ABC, 1'b0, 0, 0, 0},
        '{FR_BAD_HDR, 16'h4000, 16'hC000, 16'h2000, 1'b0, 0, 0, 0},
        '{FR_BAD_SUM, 16'h0100, 16'hFF00, 16'h00FF, 1'b0, 0, 0, 0},
        '{FR_ANGLE,   16'h04D2, 16'hF830, 16'h7530, 1'b0, 0, 0, 0},
        '{FR_ANGLE,   16'hAAAA, 16'h5555, 16'h8001, 1'b0, 0, 0, 0}
    };

    int         phase_offset[PHASES] = '{32768, -32768, -65536, 65535, 0, 0};
    logic [2:0] phase_invert[PHASES] = '{3'b111, 3'b101, 3'b010, 3'b111, 3'b000, 3'b000};

    imu_angle_frame_parser dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .roll_angle  (roll_angle),
        .pitch_angle (pitch_angle),
        .yaw_angle   (yaw_angle),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic int wrap_half_turn(input int v);
        if (v > HALF_TURN)
            return v - FULL_TURN;
        else if (v <= -HALF_TURN)
            return v + FULL_TURN;
        return v;
    endfunction

    function automatic bit feed_window_byte(input logic [7:0] b, output angles_t res);
        logic [7:0]         sum;
        logic signed [15:0] raw;
        int                 r;
        int                 p;
        int                 y;
        res = '0;
        if (win_fill >= WIN_LEN)
            win_fill = 0;
        win_bytes[win_fill] = b;
        win_fill++;
        if (win_fill < WIN_LEN)
            return 1'b0;
        sum = 8'h00;
        for (int i = 0; i < WIN_LEN - 1; i++)
            sum += win_bytes[i];
        if (win_bytes[0] != HDR_BYTE || sum != win_bytes[WIN_LEN-1])
        begin
            for (int i = 0; i < WIN_LEN - 1; i++)
                win_bytes[i] = win_bytes[i+1];
            win_fill = WIN_LEN - 1;
            return 1'b0;
        end
        win_fill = 0;
        if (win_bytes[1] != TYPE_ANGLE)
            return 1'b0;
        raw = {win_bytes[3], win_bytes[2]};
        r = raw;
        raw = {win_bytes[5], win_bytes[4]};
        p = raw;
        raw = {win_bytes[7], win_bytes[6]};
        y = raw;
        if (inv_roll)
            r = -r;
        if (inv_pitch)
            p = -p;
        if (inv_yaw)
            y = -y;
        y = wrap_half_turn(y);
        y = wrap_half_turn(y - yaw_offset);
        res.roll  = r[ANGLE_W-1:0];
        res.pitch = p[ANGLE_W-1:0];
        res.yaw   = y[ANGLE_W-1:0];
        return 1'b1;
    endfunction

    always @(posedge clk)
    begin
        angles_t a;
        if (rst_n && in_valid && !in_stall)
        begin
            if (feed_window_byte(rx_byte, a))
            begin
                if (literal_armed)
                begin
                    angle_expect_q.push_back(literal_want);
                    literal_armed = 1'b0;
                end
                else
                    angle_expect_q.push_back(a);
            end
        end
    end

    always @(posedge clk)
    begin
        angles_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (angle_expect_q.size() == 0)
            begin
                $error("unexpected result: roll %0d pitch %0d yaw %0d",
                       roll_angle, pitch_angle, yaw_angle);
                error_count++;
            end
            else
            begin
                e = angle_expect_q.pop_front();
                if (roll_angle !== e.roll)
                begin
                    $error("roll_angle: expected %0d, got %0d", e.roll, roll_angle);
                    error_count++;
                end
                if (pitch_angle !== e.pitch)
                begin
                    $error("pitch_angle: expected %0d, got %0d", e.pitch, pitch_angle);
                    error_count++;
                end
                if (yaw_angle !== e.yaw)
                begin
                    $error("yaw_angle: expected %0d, got %0d", e.yaw, yaw_angle);
                    error_count++;
                end
            end
        end
    end

    // hold off for a long stretch once a result is waiting, when requested
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else if (hold_requests != holds_served && out_valid)
        begin
            holds_served++;
            hold_left = HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else
        begin
            case (rx_mode)
                RX_READY:  out_stall <= 1'b0;
                RX_RANDOM: out_stall <= ($urandom_range(99) < 35);
                default:   out_stall <= ((cycle_count % 7) < 3);
            endcase
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ANGLE_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_ROLL_INVERT:  inv_roll = data[0];
            CFG_PITCH_INVERT: inv_pitch = data[0];
            CFG_YAW_INVERT:   inv_yaw = data[0];
            CFG_YAW_OFFSET:   yaw_offset = data;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic append_frame(input logic [7:0] ftype, input logic [15:0] r,
                                input logic [15:0] p, input logic [15:0] y,
                                input bit bad_hdr, input bit bad_sum);
        logic [7:0] f[WIN_LEN];
        logic [7:0] sum;
        f[0] = HDR_BYTE;
        if (bad_hdr)
        begin
            f[0] = 8'($urandom_range(255));
            if (f[0] == HDR_BYTE)
                f[0] = 8'hAA;
        end
        f[1] = ftype;
        f[2] = r[7:0];
        f[3] = r[15:8];
        f[4] = p[7:0];
        f[5] = p[15:8];
        f[6] = y[7:0];
        f[7] = y[15:8];
        f[8] = 8'($urandom_range(255));
        f[9] = 8'($urandom_range(255));
        sum = 8'h00;
        for (int i = 0; i < WIN_LEN - 1; i++)
            sum += f[i];
        f[10] = bad_sum ? sum + 8'($urandom_range(1, 255)) : sum;
        for (int i = 0; i < WIN_LEN; i++)
            tx_bytes_q.push_back(f[i]);
    endtask

    task automatic drive_bytes();
        int gap;
        while (tx_bytes_q.size() != 0)
        begin
            @(negedge clk);
            if (gaps_on && burst_left == 0)
            begin
                gap = $urandom_range(1, 8);
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
                burst_left = $urandom_range(1, 30);
            end
            in_valid <= 1'b1;
            rx_byte  <= tx_bytes_q.pop_front();
            if (burst_left > 0)
                burst_left--;
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (angle_expect_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic logic [15:0] pick_angle();
        logic [15:0] edges[5] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001};
        if ($urandom_range(3) == 0)
            return edges[3'($urandom_range(4))];
        return 16'($urandom);
    endfunction

    task automatic build_random_stream(input int nbytes);
        int         pick;
        logic [7:0] t;
        while (tx_bytes_q.size() < nbytes)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
                append_frame(TYPE_ANGLE, pick_angle(), pick_angle(), pick_angle(), 0, 0);
            else if (pick < 80)
            begin
                t = 8'($urandom_range(255));
                if (t == TYPE_ANGLE)
                    t = TYPE_ACCEL;
                append_frame(t, pick_angle(), pick_angle(), pick_angle(), 0, 0);
            end
            else if (pick < 88)
                append_frame(TYPE_ANGLE, pick_angle(), pick_angle(), pick_angle(), 0, 1);
            else if (pick < 94)
                append_frame(TYPE_ANGLE, pick_angle(), pick_angle(), pick_angle(), 1, 0);
            else
                repeat ($urandom_range(1, 15)) tx_bytes_q.push_back(8'($urandom));
        end
    endtask

    initial
    begin
        frame_row_t     row;
        logic [2:0]     inv;
        int             ofs;
        logic [7:0]     ftype;
        for (int i = 0; i < WIN_LEN; i++)
            win_bytes[i] = 8'h00;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        rx_mode = RX_RANDOM;
        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.literal)
            begin
                literal_want.roll  = row.want_roll[ANGLE_W-1:0];
                literal_want.pitch = row.want_pitch[ANGLE_W-1:0];
                literal_want.yaw   = row.want_yaw[ANGLE_W-1:0];
                literal_armed = 1'b1;
            end
            ftype = (row.kind == FR_OTHER) ? TYPE_ACCEL : TYPE_ANGLE;
            append_frame(ftype, row.roll, row.pitch, row.yaw,
                         row.kind == FR_BAD_HDR, row.kind == FR_BAD_SUM);
            drive_bytes();
        end
        wait_idle();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            inv = phase_invert[ph];
            ofs = phase_offset[ph];
            if (ph == PHASES - 1)
            begin
                inv = 3'($urandom);
                ofs = $urandom_range(131071);
            end
            write_reg(CFG_ROLL_INVERT,  {16'($urandom), inv[2]});
            write_reg(CFG_PITCH_INVERT, {16'($urandom), inv[1]});
            write_reg(CFG_YAW_INVERT,   {16'($urandom), inv[0]});
            write_reg(CFG_YAW_OFFSET,   ofs[ANGLE_W-1:0]);
            write_reg((ph == 0) ? 8'hFF : 8'($urandom_range(4, 255)), 17'($urandom));
            gaps_on = (ph != 0);
            rx_mode = rx_mode_t'(ph % 3);
            if (ph == 2)
                hold_requests++;
            build_random_stream(PHASE_BYTES);
            drive_bytes();
            wait_idle();
        end

        repeat (8) @(posedge clk);
        if (angle_expect_q.size() != 0)
        begin
            $error("%0d expected results never arrived", angle_expect_q.size());
            error_count++;
        end
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
